[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/s2cj_pkg.sv]
package s2cj_pkg;

  localparam int RANGE_BITS_DEF     = 24;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 15;

  localparam int PW = 32;
  typedef logic signed [PW-1:0] pw_t;

  localparam pw_t POLY_C9 = 32'sd172272;
  localparam pw_t POLY_C7 = -32'sd5026994;
  localparam pw_t POLY_C5 = 32'sd85569306;
  localparam pw_t POLY_C3 = -32'sd693598669;
  localparam pw_t POLY_C1 = 32'sd1686629713;

  typedef enum logic [1:0] {
    CONV_ENU   = 2'd0,
    CONV_YUP   = 2'd1,
    CONV_POLAR = 2'd2,
    CONV_SWAP  = 2'd3
  } conv_e;

  function automatic pw_t horner_coef(int k);
    pw_t c;
    case (k)
      0:       c = POLY_C7;
      1:       c = POLY_C5;
      2:       c = POLY_C3;
      default: c = POLY_C1;
    endcase
    return c;
  endfunction

  function automatic pw_t mul_q30(pw_t a, pw_t b);
    logic signed [2*PW-1:0] pr;
    pr = a * b;
    return pw_t'(pr[PW+29:30]);
  endfunction

endpackage

[rtl/core/spherical_to_cartesian_jacobian.sv]
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_ready_o  range_in_i, azimuth_i, elevation_i
// result    out        out_valid_o / out_ready_i nine Jacobian entries
// config    in         cfg_we_i                 cfg_wdata_i (axis convention)
// One item enters per cycle unless a stalled output holds the pipeline.
// The sine evaluators are pipelined as a square, four Horner steps and a final
// product, each one registered multiply, then trig products and the range multiply.
// Reset clears the valid bits and the convention register.
// A stalled output freezes the whole pipeline, so no transfer is lost or repeated.
module spherical_to_cartesian_jacobian
  import s2cj_pkg::*;
#(
  parameter int RANGE_BITS     = RANGE_BITS_DEF,
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [RANGE_BITS-1:0]        range_in_i,
  input  logic [ANGLE_BITS-1:0]        azimuth_i,
  input  logic [ANGLE_BITS-1:0]        elevation_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [TRIG_FRAC_BITS:0] dx_dr_o,
  output logic signed [TRIG_FRAC_BITS:0] dy_dr_o,
  output logic signed [TRIG_FRAC_BITS:0] dz_dr_o,
  output logic signed [RANGE_BITS:0]   dx_daz_o,
  output logic signed [RANGE_BITS:0]   dy_daz_o,
  output logic signed [RANGE_BITS:0]   dz_daz_o,
  output logic signed [RANGE_BITS:0]   dx_del_o,
  output logic signed [RANGE_BITS:0]   dy_del_o,
  output logic signed [RANGE_BITS:0]   dz_del_o
);

  localparam int NS = 11;
  localparam int F  = TRIG_FRAC_BITS;
  localparam int A  = ANGLE_BITS;
  localparam int R  = RANGE_BITS;

  typedef logic signed [F:0] trig_t;
  typedef logic [R-1:0]      rng_t;

  localparam logic [A-1:0] QTR   = {2'b01, {(A-2){1'b0}}};
  localparam logic [A-2:0] QTR_U = {1'b1, {(A-2){1'b0}}};
  localparam pw_t          RND   = pw_t'(1) <<< (29 - F);
  localparam pw_t          TOP   = (pw_t'(1) <<< F) - pw_t'(1);

  logic [NS-1:0] vld_q;
  logic          en;
  logic [1:0]    conv_q;

  rng_t       r_q    [10];
  logic [1:0] quad_q [7][4];
  pw_t        t_q    [6][4];
  pw_t        t2_q   [4][4];
  pw_t        p_q    [4][4];
  pw_t        y_q    [4];
  trig_t      trig_q [4];
  trig_t      cc_q, sc_q, cs_q, ss_q, se_q, ce_q;
  trig_t      sel_q  [9];
  trig_t      dr_q   [3];
  logic [R:0] ang_q  [6];

  logic [1:0] quad_d [4];
  pw_t        t_d    [4];
  pw_t        t2_d   [4];
  pw_t        p_d    [4][4];
  pw_t        y_d    [4];
  trig_t      trig_d [4];
  trig_t      cc_d, sc_d, cs_d, ss_d;
  trig_t      sel_d  [9];
  logic [R:0] ang_d  [6];

  assign en          = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];

  function automatic trig_t trig_mul(trig_t a, trig_t b);
    logic signed [2*F+1:0] pr;
    pr = a * b;
    return trig_t'(pr[2*F:F]);
  endfunction

  always_comb begin
    logic [A-1:0] ang [4];
    logic [A-2:0] u;
    ang[0] = azimuth_i;
    ang[1] = azimuth_i + QTR;
    ang[2] = elevation_i;
    ang[3] = elevation_i + QTR;
    for (int l = 0; l < 4; l++) begin
      quad_d[l] = ang[l][A-1:A-2];
      u = {1'b0, ang[l][A-3:0]};
      if (quad_d[l][0]) begin
        u = QTR_U - u;
      end
      t_d[l] = {1'b0, u, {(32-A){1'b0}}};
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      t2_d[l]   = mul_q30(t_q[0][l], t_q[0][l]);
      p_d[0][l] = POLY_C7 + mul_q30(POLY_C9, t2_q[0][l]);
      for (int k = 1; k < 4; k++) begin
        p_d[k][l] = horner_coef(k) + mul_q30(p_q[k-1][l], t2_q[k][l]);
      end
      y_d[l] = mul_q30(p_q[3][l], t_q[5][l]);
    end
  end

  always_comb begin
    pw_t   qs;
    trig_t m;
    for (int l = 0; l < 4; l++) begin
      qs = (y_q[l] + RND) >>> (30 - F);
      if (qs > TOP) begin
        qs = TOP;
      end else if (qs < 0) begin
        qs = '0;
      end
      m = trig_t'(qs);
      trig_d[l] = quad_q[6][l][1] ? -m : m;
    end
    cc_d = trig_mul(trig_q[1], trig_q[3]);
    sc_d = trig_mul(trig_q[0], trig_q[3]);
    cs_d = trig_mul(trig_q[1], trig_q[2]);
    ss_d = trig_mul(trig_q[0], trig_q[2]);
  end

  always_comb begin
    case (conv_e'(conv_q))
      CONV_ENU: begin
        sel_d = '{cc_q, sc_q, se_q, -sc_q, cc_q, '0, -cs_q, -ss_q, ce_q};
      end
      CONV_YUP: begin
        sel_d = '{sc_q, se_q, cc_q, cc_q, '0, -sc_q, -ss_q, ce_q, -cs_q};
      end
      CONV_SWAP: begin
        sel_d = '{sc_q, cc_q, se_q, cc_q, -sc_q, '0, -ss_q, -cs_q, ce_q};
      end
      default: begin
        sel_d = '{cs_q, ss_q, ce_q, -ss_q, cs_q, '0, cc_q, sc_q, -se_q};
      end
    endcase
  end

  always_comb begin
    logic [F:0]     mag;
    logic [R+F:0]   pr;
    logic [R:0]     qv;
    logic           neg;
    logic           rem;
    for (int k = 0; k < 6; k++) begin
      neg = sel_q[k+3][F];
      mag = neg ? (F+1)'(-sel_q[k+3]) : sel_q[k+3];
      pr  = r_q[9] * mag;
      qv  = pr[R+F:F];
      rem = |pr[F-1:0];
      ang_d[k] = neg ? (~qv + (R+1)'(!rem)) : qv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      conv_q <= CONV_ENU;
    end else begin
      if (cfg_we_i) begin
        conv_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[NS-2:0], in_valid_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]    <= range_in_i;
      quad_q[0] <= quad_d;
      t_q[0]    <= t_d;
      for (int s = 1; s < 10; s++) begin
        r_q[s] <= r_q[s-1];
      end
      for (int s = 1; s < 7; s++) begin
        quad_q[s] <= quad_q[s-1];
      end
      for (int s = 1; s < 6; s++) begin
        t_q[s] <= t_q[s-1];
      end
      t2_q[0] <= t2_d;
      for (int s = 1; s < 4; s++) begin
        t2_q[s] <= t2_q[s-1];
      end
      p_q    <= p_d;
      y_q    <= y_d;
      trig_q <= trig_d;
      cc_q   <= cc_d;
      sc_q   <= sc_d;
      cs_q   <= cs_d;
      ss_q   <= ss_d;
      se_q   <= trig_q[2];
      ce_q   <= trig_q[3];
      sel_q  <= sel_d;
      dr_q   <= sel_q[0:2];
      ang_q  <= ang_d;
    end
  end

  assign dx_dr_o  = dr_q[0];
  assign dy_dr_o  = dr_q[1];
  assign dz_dr_o  = dr_q[2];
  assign dx_daz_o = $signed(ang_q[0]);
  assign dy_daz_o = $signed(ang_q[1]);
  assign dz_daz_o = $signed(ang_q[2]);
  assign dx_del_o = $signed(ang_q[3]);
  assign dy_del_o = $signed(ang_q[4]);
  assign dz_del_o = $signed(ang_q[5]);

endmodule

[rtl/core/s2cj_checker.sv]
`include "assert_macros.svh"

module s2cj_checker #(
  parameter int RANGE_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 15
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [TRIG_FRAC_BITS:0] dx_dr_o,
  input logic signed [RANGE_BITS:0]  dx_daz_o,
  input logic signed [RANGE_BITS:0]  dy_daz_o,
  input logic signed [RANGE_BITS:0]  dz_daz_o
);

  `AST_NXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
           out_valid_o && $stable(dx_dr_o) && $stable(dx_daz_o))
  `AST_IMP(a_ready_rule, clk_i, rst_ni, 1'b1,
           in_ready_o == (!out_valid_o || out_ready_i))
  `AST_IMP(a_zero_entry, clk_i, rst_ni, out_valid_o, dz_daz_o == 0 || dy_daz_o == 0)

endmodule

bind spherical_to_cartesian_jacobian s2cj_checker #(
  .RANGE_BITS(RANGE_BITS),
  .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
) u_s2cj_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .dx_dr_o(dx_dr_o),
  .dx_daz_o(dx_daz_o),
  .dy_daz_o(dy_daz_o),
  .dz_daz_o(dz_daz_o)
);
